@@ rtl/trcf_pkg.sv @@
// ----------------------------------------------------------------------------
// Touch report change filter package
// Shared beat types, register indexes, reset values and queue sizing.
// ----------------------------------------------------------------------------
package trcf_pkg;

	// Register indexes on the configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_COORD_MAX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REFRESH_COUNT = 2'd2;

	// Register widths and reset values
	localparam int COORD_W = 12;
	localparam int MOVE_W = 13;
	localparam int REFRESH_W = 8;
	localparam int TOTAL_W = 32;
	localparam logic [COORD_W-1:0] COORD_MAX_RST = 12'd239;
	localparam logic [MOVE_W-1:0] MOVE_THRESHOLD_RST = 13'd2;
	localparam logic [REFRESH_W-1:0] REFRESH_COUNT_RST = 8'd25;

	// Two-entry queues between the parts
	localparam int Q_PTR_W = 1;
	localparam logic [Q_PTR_W:0] Q_DEPTH = 2'd2;

	// Input beat: the six raw report bytes
	typedef struct packed {
		logic [7:0] gesture_byte;
		logic [7:0] points_byte;
		logic [7:0] x_high_byte;
		logic [7:0] x_low_byte;
		logic [7:0] y_high_byte;
		logic [7:0] y_low_byte;
	} in_t;

	// Decoded report handed from front to back
	typedef struct packed {
		logic [3:0]         points;
		logic [1:0]         kind;
		logic [7:0]         gesture;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
	} dec_t;

	// Result beat
	typedef struct packed {
		logic               report_flag;
		logic [3:0]         touch_points;
		logic [1:0]         touch_kind;
		logic [7:0]         gesture_code;
		logic [COORD_W-1:0] screen_x;
		logic [COORD_W-1:0] screen_y;
		logic [TOTAL_W-1:0] flagged_total;
	} res_t;

	// Back-end status seen by the top level
	typedef struct packed {
		logic               fire;
		logic               flag;
		logic [TOTAL_W-1:0] total;
	} back_stat_t;

endpackage

@@ rtl/trcf_front.sv @@
// ----------------------------------------------------------------------------
// Touch report front end
// Decodes a raw report, clamps and rotates the coordinates and queues the
// decoded report for the back end.
// ----------------------------------------------------------------------------
module trcf_front import trcf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  in_t                report,
	input  logic [COORD_W-1:0] coord_max,
	output logic               deq_valid,
	input  logic               deq_pop,
	output dec_t               deq_data
);

	logic [COORD_W-1:0] raw_x;
	logic [COORD_W-1:0] raw_y;
	logic [COORD_W-1:0] lim_x;
	dec_t               dec;
	logic               wr_en;
	logic               rd_en;

	dec_t               mem_q [2];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   cnt_q;

	// Field decode, clamp and rotation
	always_comb begin
		raw_x       = {report.x_high_byte[3:0], report.x_low_byte};
		raw_y       = {report.y_high_byte[3:0], report.y_low_byte};
		lim_x       = (raw_x > coord_max) ? coord_max : raw_x;
		dec.points  = report.points_byte[3:0];
		dec.kind    = report.x_high_byte[7:6];
		dec.gesture = report.gesture_byte;
		dec.sx      = (raw_y > coord_max) ? coord_max : raw_y;
		dec.sy      = coord_max - lim_x;
	end

	assign full      = (cnt_q == Q_DEPTH);
	assign deq_valid = (cnt_q != '0);
	assign wr_en     = push && !full;
	assign rd_en     = deq_pop && deq_valid;
	assign deq_data  = mem_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/trcf_back.sv @@
// ----------------------------------------------------------------------------
// Touch report back end
// Compares each decoded report with the previous one, decides the flag,
// keeps the flag count and queues result beats.
// ----------------------------------------------------------------------------
module trcf_back import trcf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 deq_valid,
	output logic                 deq_pop,
	input  dec_t                 deq_data,
	input  logic [MOVE_W-1:0]    move_threshold,
	input  logic [REFRESH_W-1:0] refresh_count,
	output logic                 empty,
	input  logic                 pop,
	output res_t                 result,
	output back_stat_t           stat
);

	// Previous report and run state
	logic [3:0]           last_points_q;
	logic [1:0]           last_kind_q;
	logic [7:0]           last_gesture_q;
	logic [COORD_W-1:0]   last_x_q;
	logic [COORD_W-1:0]   last_y_q;
	logic                 have_last_q;
	logic [REFRESH_W-1:0] silent_q;
	logic [TOTAL_W-1:0]   total_q;

	logic [COORD_W-1:0]   dx;
	logic [COORD_W-1:0]   dy;
	logic [MOVE_W-1:0]    movement;
	logic [REFRESH_W-1:0] silent_inc;
	logic                 active;
	logic                 changed;
	logic                 flag;
	logic                 bump_silent;
	logic [TOTAL_W-1:0]   total_next;
	logic                 fire;
	logic                 res_full;
	logic                 rd_en;
	res_t                 res;

	res_t                 mem_q [2];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_PTR_W:0]     cnt_q;

	// Flag decision
	always_comb begin
		dx = (deq_data.sx > last_x_q) ? deq_data.sx - last_x_q : last_x_q - deq_data.sx;
		dy = (deq_data.sy > last_y_q) ? deq_data.sy - last_y_q : last_y_q - deq_data.sy;
		movement    = {1'b0, dx} + {1'b0, dy};
		silent_inc  = silent_q + 1'b1;
		active      = (deq_data.points != '0);
		changed     = (deq_data.points != last_points_q) || (deq_data.kind != last_kind_q)
			|| (deq_data.gesture != last_gesture_q);
		bump_silent = 1'b0;
		priority if (!have_last_q) begin
			flag = active || (deq_data.gesture != '0);
		end else if (changed) begin
			flag = 1'b1;
		end else if (active && (movement >= move_threshold)) begin
			flag = 1'b1;
		end else if (active) begin
			bump_silent = 1'b1;
			flag = (silent_inc >= refresh_count);
		end else begin
			flag = 1'b0;
		end
		total_next = total_q + {{(TOTAL_W-1){1'b0}}, flag};
	end

	assign res_full = (cnt_q == Q_DEPTH);
	assign fire     = deq_valid && !res_full;
	assign deq_pop  = fire;

	always_comb begin
		res.report_flag   = flag;
		res.touch_points  = deq_data.points;
		res.touch_kind    = deq_data.kind;
		res.gesture_code  = deq_data.gesture;
		res.screen_x      = deq_data.sx;
		res.screen_y      = deq_data.sy;
		res.flagged_total = total_next;
	end

	// Previous report registers (payload, written on every beat)
	always_ff @(posedge clk) begin
		if (fire) begin
			last_points_q  <= deq_data.points;
			last_kind_q    <= deq_data.kind;
			last_gesture_q <= deq_data.gesture;
			last_x_q       <= deq_data.sx;
			last_y_q       <= deq_data.sy;
		end
	end

	// Run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_last_q <= 1'b0;
			silent_q    <= '0;
			total_q     <= '0;
		end else if (fire) begin
			have_last_q <= 1'b1;
			total_q     <= total_next;
			if (flag) begin
				silent_q <= '0;
			end else if (bump_silent) begin
				silent_q <= silent_inc;
			end
		end
	end

	// Result queue storage
	assign empty  = (cnt_q == '0);
	assign rd_en  = pop && !empty;
	assign result = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (fire) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	// Result queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (fire) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (fire && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !fire) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign stat.fire  = fire;
	assign stat.flag  = flag;
	assign stat.total = total_q;

endmodule

@@ rtl/touch_report_change_filter_unit.sv @@
// ----------------------------------------------------------------------------
// Touch report change filter
// Decodes touch reports, rotates coordinates and flags reports worth passing on.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive a six-byte report beat on report with push high; it
//   is taken at a clock edge where full is low.
//   Result channel: while empty is low the oldest result is on result; raise
//   pop to take it.
//   Configuration: cfg_we with cfg_index and cfg_data writes coord_max (0),
//   move_threshold (1) or refresh_count (2); other indexes are dropped.
//   Write registers only while no report is in flight.
// Timing:
//   A report taken at the input is written into the decode queue, then into
//   the result queue once that has room, and is then on the result port. One
//   report per cycle is sustained while pop keeps the result queue from filling;
//   the back end compares each beat against the previous report and updates the flag count.
//   If pop stays low, the two-entry result queue fills, then the two-entry
//   queue between front and back, and full rises: four reports are held.
// Reset:
//   arst_n drops the previous report, clears the silent run and the flag count,
//   empties both queues and loads the register reset values.
// ----------------------------------------------------------------------------
module touch_report_change_filter_unit import trcf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  in_t                   report,
	output logic                  empty,
	input  logic                  pop,
	output res_t                  result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [COORD_W-1:0]   coord_max_q;
	logic [MOVE_W-1:0]    move_threshold_q;
	logic [REFRESH_W-1:0] refresh_count_q;
	logic                 deq_valid;
	logic                 deq_pop;
	dec_t                 deq_data;
	back_stat_t           stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_max_q      <= COORD_MAX_RST;
			move_threshold_q <= MOVE_THRESHOLD_RST;
			refresh_count_q  <= REFRESH_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COORD_MAX:      coord_max_q      <= cfg_data[COORD_W-1:0];
				REG_MOVE_THRESHOLD: move_threshold_q <= cfg_data[MOVE_W-1:0];
				REG_REFRESH_COUNT:  refresh_count_q  <= cfg_data[REFRESH_W-1:0];
				default: ;
			endcase
		end
	end

	trcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.report    (report),
		.coord_max (coord_max_q),
		.deq_valid (deq_valid),
		.deq_pop   (deq_pop),
		.deq_data  (deq_data)
	);

	trcf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.deq_valid      (deq_valid),
		.deq_pop        (deq_pop),
		.deq_data       (deq_data),
		.move_threshold (move_threshold_q),
		.refresh_count  (refresh_count_q),
		.empty          (empty),
		.pop            (pop),
		.result         (result),
		.stat           (stat)
	);

`ifndef NO_ASSERTIONS
	// Flag count moves by exactly one per flagged beat and holds otherwise
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> stat.total == $past(stat.total) + {{(TOTAL_W-1){1'b0}},
			$past(stat.fire && stat.flag)})
		else $error("flag count out of step with flagged beats");

	// Back end only takes a decoded report that is there
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		deq_pop |-> deq_valid)
		else $error("back end popped an empty decode queue");

	// Input backpressure only when the decode queue holds work
	a_full_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> deq_valid)
		else $error("full raised with no decoded report waiting");
`endif

endmodule
